### sv/two_key_click_longpress_classifier_core_defines.svh
// assertion macros used by the classifier core rtl file
`ifndef TWO_KEY_CLICK_LONGPRESS_CLASSIFIER_CORE_DEFINES_SVH
`define TWO_KEY_CLICK_LONGPRESS_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TKC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TKC_ASSERT(lbl, prop, msg)
`define TKC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/tkc_pkg.sv
package tkc_pkg;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned EV_W  = 4;
  localparam int unsigned KEY_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [EV_W-1:0]  ev_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam key_t KEY_NONE = 2'd0;
  localparam key_t KEY_1    = 2'd1;
  localparam key_t KEY_2    = 2'd2;
  localparam key_t KEY_BOTH = 2'd3;

  localparam ev_t EV_NONE    = 4'd0;
  localparam ev_t EV_K1_BASE = 4'd0;
  localparam ev_t EV_K2_BASE = 4'd4;
  localparam ev_t EV_LONG    = 4'd4;

  localparam cfg_idx_t CFG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t CFG_LONG     = 2'd1;
  localparam cfg_idx_t CFG_GAP      = 2'd2;

  localparam cnt_t DEBOUNCE_RST = 8'd5;
  localparam cnt_t LONG_RST     = 8'd200;
  localparam cnt_t GAP_RST      = 8'd100;

  typedef struct packed {
    cnt_t debounce_ticks;
    cnt_t long_ticks;
    cnt_t gap_ticks;
  } tkc_cfg_t;

  typedef struct packed {
    cnt_t press_count;
    cnt_t release_count;
    cnt_t gap_count;
    cnt_t click_tally;
    logic pressed_flag;
    logic repeat_flag;
    logic long_flag;
    key_t pending_key;
    key_t held_code;
  } tkc_state_t;

endpackage

### sv/tkc_in_if.sv
interface tkc_in_if;
  logic valid;
  logic ready;
  logic key1_pin;
  logic key2_pin;

  modport source (output valid, output key1_pin, output key2_pin, input ready);
  modport sink (input valid, input key1_pin, input key2_pin, output ready);
endinterface

### sv/tkc_out_if.sv
interface tkc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink (input valid, input event_res, output ready);
endinterface

### sv/tkc_step.sv
module tkc_step (
  input  tkc_pkg::tkc_state_t cur_st,
  input  tkc_pkg::tkc_cfg_t   cfg,
  input  logic                key1_pin,
  input  logic                key2_pin,
  output tkc_pkg::tkc_state_t nxt_st,
  output tkc_pkg::ev_t        ev
);
  import tkc_pkg::*;

  tkc_state_t s;
  ev_t        e;
  key_t       code;
  key_t       kc;
  ev_t        base;
  logic       rep;
  logic       act;

  always_comb begin
    s    = cur_st;
    e    = EV_NONE;
    code = {~key2_pin, ~key1_pin};
    kc   = KEY_NONE;
    base = EV_K1_BASE;
    rep  = 1'b0;
    act  = 1'b0;

    // debounce
    if (code != KEY_NONE) begin
      s.press_count = s.press_count + 8'd1;
      if (s.press_count > cfg.debounce_ticks) begin
        if (s.pressed_flag) begin
          s.repeat_flag = 1'b1;
        end else begin
          s.pressed_flag = 1'b1;
        end
        s.pending_key = KEY_NONE;
        s.held_code   = code;
        s.press_count = '0;
        s.gap_count   = '0;
      end
    end else begin
      s.press_count = '0;
    end

    unique case (s.held_code)
      KEY_1: begin
        kc   = KEY_1;
        base = EV_K1_BASE;
        rep  = 1'b1;
        act  = 1'b1;
      end
      KEY_2: begin
        kc   = KEY_2;
        base = EV_K2_BASE;
        rep  = 1'b0;
        act  = 1'b1;
      end
      default: begin
        kc  = KEY_NONE;
        act = 1'b0;
      end
    endcase

    if (s.pressed_flag) begin
      s.release_count = s.release_count + 8'd1;
      if (act) begin
        if (code == KEY_NONE) begin
          if (s.release_count > cfg.long_ticks) begin
            s.release_count = cfg.long_ticks + 8'd1;
          end
          if (s.pending_key == kc) begin
            s.gap_count = s.gap_count + 8'd1;
            if (s.gap_count > cfg.gap_ticks) begin
              if (s.click_tally >= 8'd1 && s.click_tally <= 8'd3) begin
                e = base + s.click_tally[EV_W-1:0];
              end
              s.click_tally  = '0;
              s.gap_count    = '0;
              s.pressed_flag = 1'b0;
              s.pending_key  = KEY_NONE;
              s.repeat_flag  = 1'b0;
            end
          end else if (s.release_count < cfg.long_ticks && !s.long_flag) begin
            s.pending_key = kc;
            if (s.repeat_flag) begin
              s.click_tally = s.click_tally + 8'd1;
            end else begin
              s.click_tally = 8'd1;
            end
            s.release_count = '0;
            s.repeat_flag   = 1'b0;
          end else begin
            s.long_flag     = 1'b0;
            s.release_count = '0;
            s.pressed_flag  = 1'b0;
            s.repeat_flag   = 1'b0;
          end
        end else if (code == kc) begin
          if (s.release_count > cfg.long_ticks && (rep || !s.long_flag)) begin
            e               = base + EV_LONG;
            s.release_count = '0;
            s.repeat_flag   = 1'b0;
            s.gap_count     = '0;
            s.pending_key   = KEY_NONE;
            s.long_flag     = 1'b1;
          end
        end
      end
    end

    // key 1 gap counter takes a second step
    if (s.pending_key == KEY_1) begin
      s.gap_count = s.gap_count + 8'd1;
    end

    nxt_st = s;
    ev     = e;
  end

endmodule

### sv/two_key_click_longpress_classifier_core.sv
// Classifies two active-low keys into click and long-press events. Every accepted
// input transfer is one scan tick and yields exactly one result transfer carrying
// event_res (0 none, 1-3 key 1 clicks, 4 key 1 long, 5-7 key 2 clicks, 8 key 2
// long). The block takes one tick per cycle while the output is not stalled: a
// tick is held in an input register, and from there the debounce, hold and gap
// counters are updated in one step as the event moves into the output register.
// A stalled output holds one result and one further tick before input ready drops.
// Configuration registers take effect for the next tick; the user must write them
// only while no tick is in flight, as the block itself does not enforce it.
`include "two_key_click_longpress_classifier_core_defines.svh"

module two_key_click_longpress_classifier_core (
  input  logic                   clk,
  input  logic                   rst_n,
  tkc_in_if.sink                 in_ch,
  tkc_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  tkc_pkg::cfg_idx_t      cfg_idx,
  input  logic [7:0]             cfg_wdata
);
  import tkc_pkg::*;

  tkc_cfg_t   cfg_r;
  tkc_state_t st_r;
  tkc_state_t st_nxt;
  ev_t        ev_nxt;

  logic s1_valid_r;
  logic s1_k1_r;
  logic s1_k2_r;
  logic out_valid_r;
  ev_t  out_event_r;
  logic adv;
  logic in_xfer;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.event_res = out_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
      cfg_r.long_ticks     <= LONG_RST;
      cfg_r.gap_ticks      <= GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_wdata;
        CFG_LONG:     cfg_r.long_ticks     <= cfg_wdata;
        CFG_GAP:      cfg_r.gap_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_k1_r <= in_ch.key1_pin;
      s1_k2_r <= in_ch.key2_pin;
    end
  end

  tkc_step u_step (
    .cur_st   (st_r),
    .cfg      (cfg_r),
    .key1_pin (s1_k1_r),
    .key2_pin (s1_k2_r),
    .nxt_st   (st_nxt),
    .ev       (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_event_r <= ev_nxt;
    end
  end

  `TKC_ASSERT(a_state_hold, !adv |=> $stable(st_r), "state changed without a tick")
  `TKC_ASSERT(a_tick_kept, s1_valid_r && !adv |=> s1_valid_r, "buffered tick dropped")
  `TKC_ASSERT(a_pending_legal, st_r.pending_key != KEY_BOTH, "pending key names both keys")
  `TKC_ASSERT(a_result_follows, adv |=> out_valid_r, "tick update produced no result")

endmodule
